// File: rtl/core/tccw_pkg.sv
package tccw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int BOTTOM_BASE    = SCREEN_COLUMNS * (SCREEN_ROWS - 1);

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = $clog2(CELL_COUNT);
    localparam int CELL_W = 16;

    localparam logic [7:0] RESET_ATTRIBUTE = 8'h17;
    localparam logic [7:0] CH_NUL          = 8'h00;
    localparam logic [7:0] CH_BACKSPACE    = 8'h08;
    localparam logic [7:0] CH_TAB          = 8'h09;
    localparam logic [7:0] CH_NEWLINE      = 8'h0A;
    localparam logic [7:0] CH_RETURN       = 8'h0D;
    localparam logic [7:0] CH_SPACE        = 8'h20;

    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [CELL_W-1:0] cell_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        row_t       read_row;
        col_t       read_col;
    } tccw_in_t;

    typedef struct packed {
        row_t  cursor_row;
        col_t  cursor_col;
        cell_t cell_value;
        logic  scrolled;
    } tccw_out_t;

    typedef enum logic [1:0] {
        ACT_PUT    = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_ANCHOR = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CK_NUL,
        CK_NEWLINE,
        CK_RETURN,
        CK_TAB,
        CK_BACKSPACE,
        CK_PRINT
    } char_kind_t;

    typedef enum logic [1:0] {
        RD_ITEM,
        RD_BACK,
        RD_SCROLL
    } rd_sel_t;

    typedef enum logic [1:0] {
        WA_SWEEP,
        WA_BOTTOM,
        WA_CURSOR,
        WA_CURSOR_PREV
    } wa_sel_t;

    typedef enum logic [1:0] {
        WD_BLANK,
        WD_RESET_BLANK,
        WD_CHAR
    } wd_sel_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_COL_ZERO,
        CUR_ADV,
        CUR_RETREAT,
        CUR_BACK_WRAP,
        CUR_NEWLINE
    } cur_op_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_CLEAR,
        ST_READ_WAIT,
        ST_NEWLINE,
        ST_WRAP_CHECK,
        ST_TAB,
        ST_BS_READ,
        ST_BS_WAIT,
        ST_BS_DECIDE,
        ST_BS_TAB,
        ST_BS_STEP,
        ST_BS_BLANK,
        ST_SCROLL_COPY,
        ST_SCROLL_DRAIN,
        ST_SCROLL_BLANK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic    load_item;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        cur_op_t cur_op;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    anchor_set;
        logic    anchor_clr;
        logic    tl_init;
        logic    set_scrolled;
        logic    cap_value;
        logic    out_load;
    } tccw_cmd_t;

    typedef struct packed {
        action_t    action;
        char_kind_t kind;
        logic       read_in_range;
        logic       at_anchor;
        logic       col_tab_bs;
        logic       col_last_of_quad;
        logic       col_in_row;
        logic       col_ge_cols;
        logic       row_last;
        logic       tab_like;
        logic       cnt_cells_end;
        logic       cnt_copy_end;
        logic       cnt_row_end;
        logic       cnt_quad_end;
        logic       out_free;
    } tccw_status_t;

endpackage

// File: rtl/core/tccw_ctrl.sv
module tccw_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  tccw_pkg::tccw_status_t status,
    output tccw_pkg::tccw_cmd_t    cmd
);

    tccw_pkg::state_t state_reg;
    tccw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tccw_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_stall = (state_reg != tccw_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = tccw_pkg::RD_ITEM;
        cmd.wa_sel = tccw_pkg::WA_CURSOR;
        cmd.wd_sel = tccw_pkg::WD_BLANK;
        cmd.cur_op = tccw_pkg::CUR_HOLD;

        case (state_reg)
            tccw_pkg::ST_INIT:
            begin
                // Fill every cell with a blank in the reset attribute.
                cmd.wr_en   = 1'b1;
                cmd.wa_sel  = tccw_pkg::WA_SWEEP;
                cmd.wd_sel  = tccw_pkg::WD_RESET_BLANK;
                cmd.cnt_inc = 1'b1;
                if (status.cnt_cells_end)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = tccw_pkg::ST_IDLE;
                end
            end

            tccw_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = tccw_pkg::ST_DISPATCH;
                end
            end

            tccw_pkg::ST_DISPATCH:
            begin
                case (status.action)
                    tccw_pkg::ACT_CLEAR:
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = tccw_pkg::ST_CLEAR;
                    end
                    tccw_pkg::ACT_ANCHOR:
                    begin
                        cmd.anchor_set = 1'b1;
                        state_next     = tccw_pkg::ST_DONE;
                    end
                    tccw_pkg::ACT_READ:
                    begin
                        if (status.read_in_range)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = tccw_pkg::RD_ITEM;
                            state_next = tccw_pkg::ST_READ_WAIT;
                        end
                        else
                        begin
                            state_next = tccw_pkg::ST_DONE;
                        end
                    end
                    default:
                    begin
                        case (status.kind)
                            tccw_pkg::CK_NEWLINE:
                            begin
                                state_next = tccw_pkg::ST_NEWLINE;
                            end
                            tccw_pkg::CK_RETURN:
                            begin
                                cmd.cur_op = tccw_pkg::CUR_COL_ZERO;
                                state_next = tccw_pkg::ST_DONE;
                            end
                            tccw_pkg::CK_TAB:
                            begin
                                state_next = tccw_pkg::ST_TAB;
                            end
                            tccw_pkg::CK_BACKSPACE:
                            begin
                                if (status.at_anchor)
                                begin
                                    state_next = tccw_pkg::ST_DONE;
                                end
                                else if (status.col_tab_bs)
                                begin
                                    cmd.cnt_clr = 1'b1;
                                    cmd.tl_init = 1'b1;
                                    state_next  = tccw_pkg::ST_BS_READ;
                                end
                                else
                                begin
                                    state_next = tccw_pkg::ST_BS_STEP;
                                end
                            end
                            tccw_pkg::CK_PRINT:
                            begin
                                cmd.wr_en  = 1'b1;
                                cmd.wa_sel = tccw_pkg::WA_CURSOR;
                                cmd.wd_sel = tccw_pkg::WD_CHAR;
                                cmd.cur_op = tccw_pkg::CUR_ADV;
                                state_next = tccw_pkg::ST_WRAP_CHECK;
                            end
                            default:
                            begin
                                state_next = tccw_pkg::ST_DONE;
                            end
                        endcase
                    end
                endcase
            end

            tccw_pkg::ST_CLEAR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wa_sel  = tccw_pkg::WA_SWEEP;
                cmd.wd_sel  = tccw_pkg::WD_BLANK;
                cmd.cnt_inc = 1'b1;
                if (status.cnt_cells_end)
                begin
                    cmd.cnt_clr    = 1'b1;
                    cmd.cur_op     = tccw_pkg::CUR_ZERO;
                    cmd.anchor_clr = 1'b1;
                    state_next     = tccw_pkg::ST_DONE;
                end
            end

            tccw_pkg::ST_READ_WAIT:
            begin
                cmd.cap_value = 1'b1;
                state_next    = tccw_pkg::ST_DONE;
            end

            tccw_pkg::ST_NEWLINE:
            begin
                if (status.row_last)
                begin
                    cmd.cnt_clr      = 1'b1;
                    cmd.cur_op       = tccw_pkg::CUR_COL_ZERO;
                    cmd.set_scrolled = 1'b1;
                    state_next       = tccw_pkg::ST_SCROLL_COPY;
                end
                else
                begin
                    cmd.cur_op = tccw_pkg::CUR_NEWLINE;
                    state_next = tccw_pkg::ST_DONE;
                end
            end

            tccw_pkg::ST_WRAP_CHECK:
            begin
                if (status.col_ge_cols)
                begin
                    state_next = tccw_pkg::ST_NEWLINE;
                end
                else
                begin
                    state_next = tccw_pkg::ST_DONE;
                end
            end

            tccw_pkg::ST_TAB:
            begin
                // One blank per cycle until the column reaches a multiple of four.
                cmd.wr_en  = status.col_in_row;
                cmd.wa_sel = tccw_pkg::WA_CURSOR;
                cmd.wd_sel = tccw_pkg::WD_BLANK;
                cmd.cur_op = tccw_pkg::CUR_ADV;
                if (status.col_last_of_quad)
                begin
                    state_next = tccw_pkg::ST_WRAP_CHECK;
                end
            end

            tccw_pkg::ST_BS_READ:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = tccw_pkg::RD_BACK;
                cmd.cnt_inc = 1'b1;
                if (status.cnt_quad_end)
                begin
                    state_next = tccw_pkg::ST_BS_WAIT;
                end
            end

            tccw_pkg::ST_BS_WAIT:
            begin
                // The last of the four cells is compared during this cycle.
                state_next = tccw_pkg::ST_BS_DECIDE;
            end

            tccw_pkg::ST_BS_DECIDE:
            begin
                if (status.tab_like)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = tccw_pkg::ST_BS_TAB;
                end
                else
                begin
                    state_next = tccw_pkg::ST_BS_STEP;
                end
            end

            tccw_pkg::ST_BS_TAB:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wa_sel  = tccw_pkg::WA_CURSOR_PREV;
                cmd.wd_sel  = tccw_pkg::WD_BLANK;
                cmd.cur_op  = tccw_pkg::CUR_RETREAT;
                cmd.cnt_inc = 1'b1;
                if (status.cnt_quad_end)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = tccw_pkg::ST_DONE;
                end
            end

            tccw_pkg::ST_BS_STEP:
            begin
                cmd.cur_op = tccw_pkg::CUR_BACK_WRAP;
                state_next = tccw_pkg::ST_BS_BLANK;
            end

            tccw_pkg::ST_BS_BLANK:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = tccw_pkg::WA_CURSOR;
                cmd.wd_sel = tccw_pkg::WD_BLANK;
                state_next = tccw_pkg::ST_DONE;
            end

            tccw_pkg::ST_SCROLL_COPY:
            begin
                // Reads run one row ahead; the datapath writes each cell in the cycle after its read.
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = tccw_pkg::RD_SCROLL;
                cmd.cnt_inc = 1'b1;
                if (status.cnt_copy_end)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = tccw_pkg::ST_SCROLL_DRAIN;
                end
            end

            tccw_pkg::ST_SCROLL_DRAIN:
            begin
                state_next = tccw_pkg::ST_SCROLL_BLANK;
            end

            tccw_pkg::ST_SCROLL_BLANK:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wa_sel  = tccw_pkg::WA_BOTTOM;
                cmd.wd_sel  = tccw_pkg::WD_BLANK;
                cmd.cnt_inc = 1'b1;
                if (status.cnt_row_end)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = tccw_pkg::ST_DONE;
                end
            end

            tccw_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = tccw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tccw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/tccw_datapath.sv
module tccw_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tccw_pkg::tccw_in_t     cmd_item,
    output logic                   res_valid,
    input  logic                   res_stall,
    output tccw_pkg::tccw_out_t    res_item,
    input  logic                   attr_we,
    input  logic [7:0]             attr_wdata,
    input  tccw_pkg::tccw_cmd_t    cmd,
    output tccw_pkg::tccw_status_t status
);

    tccw_pkg::cell_t cells [tccw_pkg::CELL_COUNT];

    tccw_pkg::tccw_in_t  item_reg;
    tccw_pkg::tccw_out_t out_reg;
    logic                out_valid_reg;
    logic [7:0]          attr_reg;
    tccw_pkg::row_t      row_reg;
    tccw_pkg::row_t      row_next;
    tccw_pkg::col_t      col_reg;
    tccw_pkg::col_t      col_next;
    tccw_pkg::pos_t      anchor_reg;
    tccw_pkg::pos_t      cnt_reg;
    tccw_pkg::cell_t     rdata_reg;
    tccw_pkg::cell_t     value_reg;
    logic                scrolled_reg;
    logic                tab_like_reg;
    logic                chk_valid_reg;
    logic                copy_valid_reg;
    tccw_pkg::pos_t      copy_addr_reg;

    tccw_pkg::pos_t      cursor_pos;
    tccw_pkg::pos_t      item_pos;
    tccw_pkg::pos_t      raddr;
    tccw_pkg::pos_t      waddr;
    tccw_pkg::cell_t     wdata;
    logic                we;
    logic [7:0]          ch;

    assign cursor_pos = tccw_pkg::pos_t'(tccw_pkg::pos_t'(row_reg)
                        * tccw_pkg::pos_t'(tccw_pkg::SCREEN_COLUMNS))
                        + tccw_pkg::pos_t'(col_reg);
    assign item_pos   = tccw_pkg::pos_t'(tccw_pkg::pos_t'(item_reg.read_row)
                        * tccw_pkg::pos_t'(tccw_pkg::SCREEN_COLUMNS))
                        + tccw_pkg::pos_t'(item_reg.read_col);
    assign ch         = item_reg.char_code;

    // Read address.
    always_comb
    begin
        case (cmd.rd_sel)
            tccw_pkg::RD_BACK:
                raddr = cursor_pos - tccw_pkg::pos_t'(1) - cnt_reg;
            tccw_pkg::RD_SCROLL:
                raddr = cnt_reg + tccw_pkg::pos_t'(tccw_pkg::SCREEN_COLUMNS);
            default:
                raddr = item_pos;
        endcase
    end

    // Write port: the delayed scroll copy and the commanded writes never meet.
    always_comb
    begin
        we = cmd.wr_en | copy_valid_reg;
        case (cmd.wa_sel)
            tccw_pkg::WA_SWEEP:
                waddr = cnt_reg;
            tccw_pkg::WA_BOTTOM:
                waddr = cnt_reg + tccw_pkg::pos_t'(tccw_pkg::BOTTOM_BASE);
            tccw_pkg::WA_CURSOR_PREV:
                waddr = cursor_pos - tccw_pkg::pos_t'(1);
            default:
                waddr = cursor_pos;
        endcase
        case (cmd.wd_sel)
            tccw_pkg::WD_RESET_BLANK:
                wdata = {tccw_pkg::RESET_ATTRIBUTE, tccw_pkg::CH_SPACE};
            tccw_pkg::WD_CHAR:
                wdata = {attr_reg, ch};
            default:
                wdata = {attr_reg, tccw_pkg::CH_SPACE};
        endcase
        if (copy_valid_reg)
        begin
            waddr = copy_addr_reg;
            wdata = rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cells[waddr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= cells[raddr];
        end
    end

    // Cursor movement.
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        case (cmd.cur_op)
            tccw_pkg::CUR_ZERO:
            begin
                row_next = '0;
                col_next = '0;
            end
            tccw_pkg::CUR_COL_ZERO:
            begin
                col_next = '0;
            end
            tccw_pkg::CUR_ADV:
            begin
                col_next = col_reg + tccw_pkg::col_t'(1);
            end
            tccw_pkg::CUR_RETREAT:
            begin
                col_next = col_reg - tccw_pkg::col_t'(1);
            end
            tccw_pkg::CUR_BACK_WRAP:
            begin
                if (col_reg == '0)
                begin
                    if (row_reg != '0)
                    begin
                        row_next = row_reg - tccw_pkg::row_t'(1);
                    end
                    col_next = tccw_pkg::col_t'(tccw_pkg::SCREEN_COLUMNS - 1);
                end
                else
                begin
                    col_next = col_reg - tccw_pkg::col_t'(1);
                end
            end
            tccw_pkg::CUR_NEWLINE:
            begin
                row_next = row_reg + tccw_pkg::row_t'(1);
                col_next = '0;
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg       <= tccw_pkg::RESET_ATTRIBUTE;
            row_reg        <= '0;
            col_reg        <= '0;
            anchor_reg     <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            copy_valid_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
        end
        else
        begin
            if (attr_we)
            begin
                attr_reg <= attr_wdata;
            end
            row_reg <= row_next;
            col_reg <= col_next;
            if (cmd.anchor_clr)
            begin
                anchor_reg <= '0;
            end
            else if (cmd.anchor_set)
            begin
                anchor_reg <= cursor_pos;
            end
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + tccw_pkg::pos_t'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            copy_valid_reg <= cmd.rd_en && (cmd.rd_sel == tccw_pkg::RD_SCROLL);
            chk_valid_reg  <= cmd.rd_en && (cmd.rd_sel == tccw_pkg::RD_BACK);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= cmd_item;
        end
        copy_addr_reg <= cnt_reg;
        if (cmd.load_item)
        begin
            value_reg    <= '0;
            scrolled_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cap_value)
            begin
                value_reg <= rdata_reg;
            end
            if (cmd.set_scrolled)
            begin
                scrolled_reg <= 1'b1;
            end
        end
        if (cmd.tl_init)
        begin
            tab_like_reg <= 1'b1;
        end
        else if (chk_valid_reg && (rdata_reg[7:0] != tccw_pkg::CH_SPACE))
        begin
            tab_like_reg <= 1'b0;
        end
        if (cmd.out_load)
        begin
            out_reg.cursor_row <= row_reg;
            out_reg.cursor_col <= col_reg;
            out_reg.cell_value <= value_reg;
            out_reg.scrolled   <= scrolled_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;

    always_comb
    begin
        status.action = tccw_pkg::action_t'(item_reg.action);
        case (ch)
            tccw_pkg::CH_NUL:       status.kind = tccw_pkg::CK_NUL;
            tccw_pkg::CH_NEWLINE:   status.kind = tccw_pkg::CK_NEWLINE;
            tccw_pkg::CH_RETURN:    status.kind = tccw_pkg::CK_RETURN;
            tccw_pkg::CH_TAB:       status.kind = tccw_pkg::CK_TAB;
            tccw_pkg::CH_BACKSPACE: status.kind = tccw_pkg::CK_BACKSPACE;
            default:                status.kind = tccw_pkg::CK_PRINT;
        endcase
        status.read_in_range = (item_reg.read_row < tccw_pkg::row_t'(tccw_pkg::SCREEN_ROWS))
                            && (item_reg.read_col < tccw_pkg::col_t'(tccw_pkg::SCREEN_COLUMNS));
        status.at_anchor        = (cursor_pos <= anchor_reg);
        status.col_tab_bs       = (col_reg[1:0] == 2'b00) && (col_reg >= tccw_pkg::col_t'(4));
        status.col_last_of_quad = (col_reg[1:0] == 2'b11);
        status.col_in_row       = (col_reg < tccw_pkg::col_t'(tccw_pkg::SCREEN_COLUMNS));
        status.col_ge_cols      = !status.col_in_row;
        status.row_last         = (row_reg == tccw_pkg::row_t'(tccw_pkg::SCREEN_ROWS - 1));
        status.tab_like         = tab_like_reg;
        status.cnt_cells_end    = (cnt_reg == tccw_pkg::pos_t'(tccw_pkg::CELL_COUNT - 1));
        status.cnt_copy_end     = (cnt_reg == tccw_pkg::pos_t'(tccw_pkg::BOTTOM_BASE - 1));
        status.cnt_row_end      = (cnt_reg == tccw_pkg::pos_t'(tccw_pkg::SCREEN_COLUMNS - 1));
        status.cnt_quad_end     = (cnt_reg == tccw_pkg::pos_t'(3));
        status.out_free         = !out_valid_reg || !res_stall;
    end

`ifndef NO_ASSERTIONS
    a_row_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < tccw_pkg::row_t'(tccw_pkg::SCREEN_ROWS))
        else $error("cursor row left the screen");

    a_anchor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        anchor_reg < tccw_pkg::pos_t'(tccw_pkg::CELL_COUNT))
        else $error("anchor beyond the last cell");

    a_result_col_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> col_reg < tccw_pkg::col_t'(tccw_pkg::SCREEN_COLUMNS))
        else $error("result carries a column past the row end");

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(copy_valid_reg && cmd.wr_en))
        else $error("scroll copy collided with a commanded write");

    a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !res_stall))
        else $error("result register overwritten while its beat is stalled");
`endif

endmodule

// File: rtl/core/text_console_char_writer_core.sv
// Channel   Handshake                Payload               Direction
// command   cmd_valid / cmd_stall    cmd_item (tccw_in_t)  into the block
// result    res_valid / res_stall    res_item (tccw_out_t) out of the block
// attribute attr_we                  attr_wdata[7:0]       into the block
//
// After reset the screen is filled with blanks, with cmd_stall high throughout.
// A printable byte is accepted, written with the cursor advanced, then wrap-checked before its result is loaded.
// Clears and scrolls sweep the screen one cell per cycle,
// as set by the single write port of the screen memory.
// A command beat is taken only while the controller is idle; a stalled result beat
// holds in its register while the next command is worked on.
module text_console_char_writer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  tccw_pkg::tccw_in_t  cmd_item,
    output logic                res_valid,
    input  logic                res_stall,
    output tccw_pkg::tccw_out_t res_item,
    input  logic                attr_we,
    input  logic [7:0]          attr_wdata
);

    tccw_pkg::tccw_cmd_t    cmd;
    tccw_pkg::tccw_status_t status;

    tccw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tccw_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_item   (cmd_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item),
        .attr_we    (attr_we),
        .attr_wdata (attr_wdata),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

// File: dv/text_console_char_writer_core_tb.sv
module text_console_char_writer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tccw_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int PHASE_ITEMS    = 190;
    localparam int REPORT_LINES   = 40;

    // Share of put beats that are line breaks, per random phase.
    localparam int NEWLINE_PCT [4] = '{0, 30, 3, 30};

    localparam tccw_out_t NO_RESULT   = '0;
    localparam cell_t     RESET_BLANK = {RESET_ATTRIBUTE, CH_SPACE};

    typedef struct packed {
        action_t   act;
        logic [7:0] code;
        row_t      rd_row;
        col_t      rd_col;
        logic      fixed;
        tccw_out_t fixed_res;
    } script_row_t;

    // Rows with the fixed flag carry their result; the rest go through the predictor.
    localparam script_row_t DIRECTED_SCRIPT [25] = '{
        '{ACT_READ,   CH_NUL,       5'd0,  7'd0,   1'b1, '{5'd0, 7'd0, RESET_BLANK, 1'b0}},
        '{ACT_READ,   CH_NUL,       5'd24, 7'd79,  1'b1, '{5'd0, 7'd0, RESET_BLANK, 1'b0}},
        '{ACT_READ,   8'hFF,        5'd31, 7'd127, 1'b1, '{5'd0, 7'd0, 16'h0000, 1'b0}},
        '{ACT_READ,   CH_NUL,       5'd25, 7'd0,   1'b1, '{5'd0, 7'd0, 16'h0000, 1'b0}},
        '{ACT_READ,   CH_NUL,       5'd0,  7'd80,  1'b1, '{5'd0, 7'd0, 16'h0000, 1'b0}},
        '{ACT_PUT,    CH_NUL,       5'd0,  7'd0,   1'b1, '{5'd0, 7'd0, 16'h0000, 1'b0}},
        '{ACT_PUT,    8'hFF,        5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_PUT,    8'h80,        5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_READ,   CH_NUL,       5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_PUT,    CH_TAB,       5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_PUT,    8'h41,        5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_ANCHOR, CH_NUL,       5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_PUT,    CH_BACKSPACE, 5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_PUT,    8'h42,        5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_PUT,    CH_BACKSPACE, 5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_PUT,    CH_RETURN,    5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_CLEAR,  CH_NUL,       5'd0,  7'd0,   1'b1, '{5'd0, 7'd0, 16'h0000, 1'b0}},
        '{ACT_PUT,    CH_TAB,       5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_PUT,    CH_TAB,       5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_PUT,    CH_BACKSPACE, 5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_PUT,    CH_BACKSPACE, 5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_PUT,    CH_BACKSPACE, 5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_PUT,    CH_NEWLINE,   5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_PUT,    CH_BACKSPACE, 5'd0,  7'd0,   1'b0, NO_RESULT},
        '{ACT_READ,   CH_NUL,       5'd0,  7'd79,  1'b0, NO_RESULT}
    };

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cmd_valid  = 1'b0;
    logic       cmd_stall;
    tccw_in_t   cmd_item   = '0;
    logic       res_valid;
    logic       res_stall  = 1'b0;
    tccw_out_t  res_item;
    logic       attr_we    = 1'b0;
    logic [7:0] attr_wdata = 8'h00;

    // Screen mirror and cursor state kept by the predictor.
    cell_t      screen_model [CELL_COUNT];
    int         cur_line;
    int         cur_column;
    int         anchor_pos;
    logic [7:0] text_attr;
    logic       scrolled_now;

    tccw_out_t   pending_results [$];
    tccw_out_t   oldest_result;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          burst_left     = 0;
    int unsigned stall_cycle    = 0;
    int unsigned stall_mode     = 0;

    text_console_char_writer_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item),
        .attr_we    (attr_we),
        .attr_wdata (attr_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void store_cell(int pos, logic [7:0] ch);
        screen_model[pos] = {text_attr, ch};
    endfunction

    function automatic void advance_line();
        cur_column = 0;
        cur_line++;
        if (cur_line >= SCREEN_ROWS)
        begin
            cur_line = SCREEN_ROWS - 1;
            for (int i = 0; i < BOTTOM_BASE; i++)
                screen_model[i] = screen_model[i + SCREEN_COLUMNS];
            for (int i = 0; i < SCREEN_COLUMNS; i++)
                store_cell(BOTTOM_BASE + i, CH_SPACE);
            scrolled_now = 1'b1;
        end
    endfunction

    function automatic tccw_out_t console_step(tccw_in_t cmd);
        tccw_out_t res;
        int        pos;
        int        delta;
        int        k;
        logic      tab_like;
        res = '0;
        scrolled_now = 1'b0;
        pos = cur_line * SCREEN_COLUMNS + cur_column;
        case (cmd.action)
            ACT_PUT:
            begin
                if (cmd.char_code == CH_NUL)
                begin
                end
                else if (cmd.char_code == CH_NEWLINE)
                    advance_line();
                else if (cmd.char_code == CH_RETURN)
                    cur_column = 0;
                else if (cmd.char_code == CH_TAB)
                begin
                    delta = ((cur_column + 4) & ~3) - cur_column;
                    for (k = 0; k < delta; k++)
                        if (cur_column + k < SCREEN_COLUMNS)
                            store_cell(pos + k, CH_SPACE);
                    cur_column += delta;
                    if (cur_column >= SCREEN_COLUMNS)
                        advance_line();
                end
                else if (cmd.char_code == CH_BACKSPACE)
                begin
                    if (pos > anchor_pos)
                    begin
                        // Four blanks left of a tab stop are taken back as one tab.
                        tab_like = (cur_column % 4 == 0) && (cur_column >= 4);
                        for (k = 1; k <= 4; k++)
                            if (tab_like && screen_model[pos - k][7:0] != CH_SPACE)
                                tab_like = 1'b0;
                        if (tab_like)
                        begin
                            cur_column -= 4;
                            for (k = 0; k < 4; k++)
                                store_cell(pos - 4 + k, CH_SPACE);
                        end
                        else
                        begin
                            if (cur_column == 0)
                            begin
                                if (cur_line > 0)
                                    cur_line--;
                                cur_column = SCREEN_COLUMNS - 1;
                            end
                            else
                                cur_column--;
                            store_cell(cur_line * SCREEN_COLUMNS + cur_column, CH_SPACE);
                        end
                    end
                end
                else
                begin
                    store_cell(pos, cmd.char_code);
                    cur_column++;
                    if (cur_column >= SCREEN_COLUMNS)
                        advance_line();
                end
            end
            ACT_CLEAR:
            begin
                for (k = 0; k < CELL_COUNT; k++)
                    store_cell(k, CH_SPACE);
                cur_line   = 0;
                cur_column = 0;
                anchor_pos = 0;
            end
            ACT_ANCHOR:
                anchor_pos = pos;
            default:
            begin
                if (cmd.read_row < SCREEN_ROWS && cmd.read_col < SCREEN_COLUMNS)
                    res.cell_value = screen_model[cmd.read_row * SCREEN_COLUMNS + cmd.read_col];
            end
        endcase
        res.cursor_row = row_t'(cur_line);
        res.cursor_col = col_t'(cur_column);
        res.scrolled   = scrolled_now;
        return res;
    endfunction

    function automatic tccw_in_t random_command(int newline_pct);
        tccw_in_t cmd;
        int       sel;
        cmd.char_code = 8'($urandom);
        cmd.read_row  = row_t'($urandom);
        cmd.read_col  = col_t'($urandom);
        sel = $urandom_range(0, 999);
        if (sel < 5)
            cmd.action = ACT_CLEAR;
        else if (sel < 45)
            cmd.action = ACT_ANCHOR;
        else if (sel < 165)
        begin
            cmd.action = ACT_READ;
            if ($urandom_range(0, 3) != 0)
            begin
                cmd.read_row = row_t'($urandom_range(0, SCREEN_ROWS - 1));
                cmd.read_col = col_t'($urandom_range(0, SCREEN_COLUMNS - 1));
            end
        end
        else
        begin
            cmd.action = ACT_PUT;
            if ($urandom_range(0, 99) < newline_pct)
                cmd.char_code = ($urandom_range(0, 3) == 0) ? CH_RETURN : CH_NEWLINE;
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 48)
                    cmd.char_code = 8'($urandom_range(8'h21, 8'h7E));
                else if (sel < 58)
                    cmd.char_code = CH_SPACE;
                else if (sel < 70)
                    cmd.char_code = CH_TAB;
                else if (sel < 80)
                    cmd.char_code = CH_BACKSPACE;
                else if (sel < 90)
                    cmd.char_code = 8'($urandom_range(8'h80, 8'hFF));
                else if (sel < 92)
                    cmd.char_code = CH_NUL;
            end
        end
        return cmd;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Called at a rising edge; returns at the edge that took the beat, or after the gap.
    task automatic send_command(input tccw_in_t cmd, input logic fixed,
                                input tccw_out_t fixed_res);
        tccw_out_t predicted;
        int        gap;
        cmd_item  <= cmd;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        predicted = console_step(cmd);
        pending_results.push_back(fixed ? fixed_res : predicted);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(5, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                cmd_item  <= tccw_in_t'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // The receiver switches between stall patterns, drawing each new pattern at random.
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 256 == 255)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: res_stall <= 1'b0;
            1: res_stall <= 1'($urandom_range(0, 1));
            2: res_stall <= (stall_cycle % 7) < 3;
            default: res_stall <= ($urandom_range(0, 15) == 0) ||
                                  (res_stall && $urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                oldest_result = pending_results.pop_front();
                if (res_item.cursor_row !== oldest_result.cursor_row)
                    report_mismatch($sformatf("cursor_row got %0d want %0d",
                        res_item.cursor_row, oldest_result.cursor_row));
                if (res_item.cursor_col !== oldest_result.cursor_col)
                    report_mismatch($sformatf("cursor_col got %0d want %0d",
                        res_item.cursor_col, oldest_result.cursor_col));
                if (res_item.cell_value !== oldest_result.cell_value)
                    report_mismatch($sformatf("cell_value got %h want %h",
                        res_item.cell_value, oldest_result.cell_value));
                if (res_item.scrolled !== oldest_result.scrolled)
                    report_mismatch($sformatf("scrolled got %b want %b",
                        res_item.scrolled, oldest_result.scrolled));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("text_console_char_writer_core_tb failed");
            $finish;
        end
    end

    initial
    begin
        tccw_in_t cmd;
        int       sent;
        for (int i = 0; i < CELL_COUNT; i++)
            screen_model[i] = RESET_BLANK;
        text_attr  = RESET_ATTRIBUTE;
        cur_line   = 0;
        cur_column = 0;
        anchor_pos = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_SCRIPT[i])
        begin
            cmd.action    = DIRECTED_SCRIPT[i].act;
            cmd.char_code = DIRECTED_SCRIPT[i].code;
            cmd.read_row  = DIRECTED_SCRIPT[i].rd_row;
            cmd.read_col  = DIRECTED_SCRIPT[i].rd_col;
            send_command(cmd, DIRECTED_SCRIPT[i].fixed, DIRECTED_SCRIPT[i].fixed_res);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            cmd_valid <= 1'b0;
            wait_results_drained();
            // Attribute changes only while the controller has nothing in hand.
            attr_we    <= 1'b1;
            attr_wdata <= (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom);
            @(posedge clk);
            text_attr = attr_wdata;
            attr_we   <= 1'b0;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                cmd = random_command(NEWLINE_PCT[phase]);
                send_command(cmd, 1'b0, NO_RESULT);
                if (!(cmd.action == ACT_PUT && cmd.char_code == CH_NUL))
                    sent++;
            end
        end

        cmd_valid <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("text_console_char_writer_core_tb passed");
        else
            $display("text_console_char_writer_core_tb failed");
        $finish;
    end

endmodule

// File: text_console_char_writer_core.f
rtl/core/tccw_pkg.sv
rtl/core/tccw_ctrl.sv
rtl/core/tccw_datapath.sv
rtl/core/text_console_char_writer_core.sv
dv/text_console_char_writer_core_tb.sv
